@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Shared constants, codes, the command type passed from the front end to the
// back end, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MAX_FRAME_BYTES = 4096;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int TDATA_W = 40;

	localparam logic [7:0] BYTE_START = 8'hE3;
	localparam logic [7:0] BYTE_END = 8'hE5;
	localparam logic [7:0] BYTE_ESC = 8'hE0;
	localparam logic [7:0] ESC_XOR = 8'hA0;
	localparam logic [7:0] BYTE_ACK = 8'hE1;
	localparam logic [7:0] BYTE_NACK = 8'hE2;
	localparam logic [7:0] BYTE_CAN = 8'hE4;
	localparam logic [7:0] TYPE_MAX = 8'h7F;
	localparam logic [7:0] DATA_TYPE_MAX = 8'h1F;
	localparam logic [7:0] RESP_TYPE_MAX = 8'h5F;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;
	localparam int MIN_BODY_BYTES = 5;

	typedef enum logic {
		OP_PUSH,
		OP_END
	} op_kind_t;

	// Reply and received control share one code set.
	typedef enum logic [1:0] {
		CTRL_NONE,
		CTRL_ACK,
		CTRL_NACK,
		CTRL_CAN
	} ctrl_t;

	typedef enum logic [2:0] {
		ERR_OK,
		ERR_EMPTY,
		ERR_UNKNOWN,
		ERR_SHORT,
		ERR_TYPE,
		ERR_BAD_BYTE,
		ERR_CRC,
		ERR_OVERRUN
	} err_t;

	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_RESPONSE,
		CLS_UNSOLICITED,
		CLS_NONE
	} cls_t;

	// One command from the front end. For OP_PUSH only data is used.
	// keep_retry marks a control frame or an overrun: no reply is sent and
	// the retry count stays as it is.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		err_t       pre_err;
		ctrl_t      peer;
		cls_t       cls;
		logic [7:0] ftype;
		logic       keep_retry;
	} op_t;

	function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ rtl/stuffed_frame_receiver_crc16.sv @@
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver with CRC-16 check
// Receives raw line bytes, unstuffs frames, forwards payload bytes and reports
// one status item per frame with the reply to send.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Item contents
// s_*       in         s_tvalid / s_tready   tdata[7:0] rx_byte
// m_*       out        m_tvalid / m_tready   tuser result_kind, tdata result fields
// cfg_*     in         cfg_valid / cfg_ready cfg_data retry_limit
//
// One input item is taken per cycle while the queue has room. The front end
// decodes it in the same cycle and places at most one command in a four-entry
// queue; the back end removes one command per cycle whenever its output
// register is empty or being emptied, and a result passes through the queue
// and that output register before it is presented on m_*.
// A stall on the output fills the queue, and s_tready drops only when it is
// full. Reset is asynchronous and active low; it returns the block to hunting
// for a start byte and loads retry_limit with ten. cfg_ready is always high.
//
module stuffed_frame_receiver_crc16 (
	input  logic                        clk,
	input  logic                        arst_n,
	// Raw line bytes.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	// Results.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] data_byte, [9:8] reply, [11:10] peer_control, [14:12] frame_error,
	// [16:15] frame_class, [24:17] frame_type, [36:25] payload_length,
	// [39:37] zero
	output logic [sfr_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,   // [0] result_kind
	// Retry limit register.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [7:0]                  cfg_data
);
	import sfr_pkg::*;

	logic front_valid;
	op_t  front_op;
	logic q_full;
	logic q_empty;
	logic q_pop;
	op_t  q_head;
	logic in_take;

	// An item is taken whenever the queue has room, so the front end waits on the
	// output side only once a stall there has filled the queue.
	assign s_tready = !q_full;
	assign in_take = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	sfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_take),
		.byte_data  (s_tdata),
		.op_valid   (front_valid),
		.op         (front_op)
	);

	sfr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_valid),
		.push_op (front_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head_op (q_head)
	);

	// The back end owns the retry count, the CRC and the two-byte delay; it
	// writes the result register that drives the output channel directly.
	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.op_avail  (!q_empty),
		.op        (q_head),
		.op_pop    (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_kind  (m_tuser),
		.res_data  (m_tdata)
	);

endmodule

@@ rtl/sfr_front.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame receiver front end
// Hunts for the start byte, removes escapes, checks framing and turns each
// raw byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module sfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	input  logic [7:0]     byte_data,
	output logic           op_valid,
	output sfr_pkg::op_t   op
);
	import sfr_pkg::*;

	logic             in_frame_q;
	logic             esc_q;
	logic             bad_q;
	logic [CNT_W-1:0] raw_q;
	logic [7:0]       type_q;

	logic             is_start, is_end, is_esc, is_special, overrun;
	op_t              end_op;

	assign is_start = (byte_data == BYTE_START);
	assign is_end = (byte_data == BYTE_END);
	assign is_esc = (byte_data == BYTE_ESC);
	assign is_special = (byte_data >= BYTE_ACK) && (byte_data <= BYTE_CAN);
	assign overrun = (raw_q == CNT_W'(MAX_FRAME_BYTES));

	// Status command for the end byte or an overrun.
	always_comb begin
		end_op = '0;
		end_op.kind = OP_END;
		end_op.peer = CTRL_NONE;
		end_op.ftype = (raw_q != '0) ? type_q : 8'h00;
		if (type_q <= DATA_TYPE_MAX) begin
			end_op.cls = CLS_DATA;
		end else if (type_q <= RESP_TYPE_MAX) begin
			end_op.cls = CLS_RESPONSE;
		end else begin
			end_op.cls = CLS_UNSOLICITED;
		end
		end_op.keep_retry = 1'b0;
		if (!is_end) begin
			end_op.pre_err = ERR_OVERRUN;
			end_op.keep_retry = 1'b1;
		end else if (raw_q == '0) begin
			end_op.pre_err = ERR_EMPTY;
		end else if (raw_q == CNT_W'(1)) begin
			unique case (type_q)
				BYTE_ACK: begin
					end_op.pre_err = ERR_OK;
					end_op.peer = CTRL_ACK;
					end_op.keep_retry = 1'b1;
				end
				BYTE_NACK: begin
					end_op.pre_err = ERR_OK;
					end_op.peer = CTRL_NACK;
					end_op.keep_retry = 1'b1;
				end
				BYTE_CAN: begin
					end_op.pre_err = ERR_OK;
					end_op.peer = CTRL_CAN;
					end_op.keep_retry = 1'b1;
				end
				default: begin
					end_op.pre_err = ERR_UNKNOWN;
				end
			endcase
		end else if (raw_q < CNT_W'(MIN_BODY_BYTES)) begin
			end_op.pre_err = ERR_SHORT;
		end else if (type_q > TYPE_MAX) begin
			end_op.pre_err = ERR_TYPE;
		end else if (bad_q || esc_q) begin
			end_op.pre_err = ERR_BAD_BYTE;
		end else begin
			end_op.pre_err = ERR_OK;
		end
	end

	always_comb begin
		op_valid = 1'b0;
		op = end_op;
		if (byte_valid && in_frame_q) begin
			if (is_end || overrun) begin
				op_valid = 1'b1;
			end else if (esc_q) begin
				op_valid = 1'b1;
				op = '0;
				op.kind = OP_PUSH;
				op.data = byte_data ^ ESC_XOR;
			end else if (!is_esc) begin
				op_valid = 1'b1;
				op = '0;
				op.kind = OP_PUSH;
				op.data = byte_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q <= 1'b0;
			bad_q <= 1'b0;
			raw_q <= '0;
			type_q <= 8'h00;
		end else if (byte_valid) begin
			if (!in_frame_q) begin
				if (is_start) begin
					in_frame_q <= 1'b1;
					esc_q <= 1'b0;
					bad_q <= 1'b0;
					raw_q <= '0;
					type_q <= 8'h00;
				end
			end else if (is_end || overrun) begin
				in_frame_q <= 1'b0;
			end else begin
				if (raw_q == '0) begin
					type_q <= byte_data;
				end
				raw_q <= raw_q + CNT_W'(1);
				if (esc_q) begin
					esc_q <= 1'b0;
				end else if (is_esc) begin
					esc_q <= 1'b1;
				end else if (is_special) begin
					bad_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/sfr_fifo.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame receiver command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module sfr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfr_pkg::op_t   push_op,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output sfr_pkg::op_t   head_op
);
	import sfr_pkg::*;

	op_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_op = mem[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ rtl/sfr_back.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame receiver back end
// Runs the two-byte delay and the CRC, settles the reply and retry count and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module sfr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [7:0]                 cfg_wdata,
	input  logic                       op_avail,
	input  sfr_pkg::op_t               op,
	output logic                       op_pop,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       res_kind,
	output logic [sfr_pkg::TDATA_W-1:0] res_data
);
	import sfr_pkg::*;

	localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [7:0]       limit_q;
	logic [7:0]       retry_q;
	logic [CNT_W-1:0] dc_q;
	logic [15:0]      crc_q;
	logic [7:0]       tail_q [2];
	logic             out_valid_q;
	logic             out_kind_q;
	logic [TDATA_W-1:0] out_data_q;

	logic             slot_free, take, dc_low;
	err_t             err;
	ctrl_t            reply;
	cls_t             cls;
	logic [7:0]       retry_next;
	logic [EXT_W-1:0] plen_ext;
	logic [LEN_W-1:0] plen;

	assign slot_free = !out_valid_q || res_ready;
	assign take = op_avail && slot_free;
	assign op_pop = take;
	assign dc_low = (dc_q < CNT_W'(2));

	assign res_valid = out_valid_q;
	assign res_kind = out_kind_q;
	assign res_data = out_data_q;

	// Final error, reply and retry count of a status command.
	always_comb begin
		if (op.keep_retry || op.pre_err != ERR_OK) begin
			err = op.pre_err;
		end else if (dc_low) begin
			err = ERR_BAD_BYTE;
		end else if (crc_q != {tail_q[0], tail_q[1]}) begin
			err = ERR_CRC;
		end else begin
			err = ERR_OK;
		end
		retry_next = retry_q;
		if (op.keep_retry) begin
			reply = CTRL_NONE;
		end else if (err == ERR_OK) begin
			reply = CTRL_ACK;
			retry_next = 8'h00;
		end else if (retry_q < limit_q) begin
			reply = CTRL_NACK;
			retry_next = retry_q + 8'd1;
		end else begin
			reply = CTRL_CAN;
			retry_next = 8'h00;
		end
		cls = (err == ERR_OK && !op.keep_retry) ? op.cls : CLS_NONE;
		plen_ext = dc_low ? '0 : EXT_W'(dc_q) - EXT_W'(2);
		plen = (plen_ext > EXT_W'(2**LEN_W - 1)) ? '1 : plen_ext[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (op.kind == OP_PUSH) begin
				if (dc_low) begin
					tail_q[dc_q[0]] <= op.data;
				end else begin
					tail_q[0] <= tail_q[1];
					tail_q[1] <= op.data;
				end
			end
			if (op.kind == OP_PUSH) begin
				out_kind_q <= 1'b0;
				out_data_q <= {3'b000, LEN_W'(0), 8'h00, CLS_NONE, ERR_OK, CTRL_NONE,
					CTRL_NONE, tail_q[0]};
			end else begin
				out_kind_q <= 1'b1;
				out_data_q <= {3'b000, plen, op.ftype, cls, err, op.peer, reply, 8'h00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RETRY_LIMIT_RESET;
			retry_q <= 8'h00;
			dc_q <= '0;
			crc_q <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (take) begin
				if (op.kind == OP_PUSH) begin
					dc_q <= dc_q + CNT_W'(1);
					if (!dc_low) begin
						crc_q <= crc_add(crc_q, tail_q[0]);
					end
					out_valid_q <= !dc_low;
				end else begin
					retry_q <= retry_next;
					dc_q <= '0;
					crc_q <= 16'h0000;
					out_valid_q <= 1'b1;
				end
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame receiver port checker
// Watches the top level's ports for result consistency and output stability.
// ----------------------------------------------------------------------------
module sfr_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [sfr_pkg::TDATA_W-1:0] m_tdata,
	input  logic                        m_tuser
);
	import sfr_pkg::*;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A payload item carries only its byte; status fields read as empty.
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[TDATA_W-1:8] == 32'h0000_0180)
		else $error("payload item with status fields set");

	// A status with an error never carries a frame class.
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[14:12] != ERR_OK |-> m_tdata[16:15] == CLS_NONE)
		else $error("failed frame reported with a class");

	// An ACK is sent only for a clean frame, never for a control frame.
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[9:8] == CTRL_ACK
		|-> m_tdata[14:12] == ERR_OK && m_tdata[11:10] == CTRL_NONE)
		else $error("ACK with error or control frame");

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/sfr_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench package
// Holds the CRC-16/XMODEM byte update, the expected-result record and a small
// scoreboard that tracks the receiver's frame state from accepted line bytes,
// queues the results that those bytes must cause and checks what comes out.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;

	import sfr_pkg::*;

	function automatic bit [15:0] xmodem_next(bit [15:0] crc, bit [7:0] b);
		bit [15:0] r;
		r = crc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	typedef struct {
		bit         kind;
		bit [7:0]   data;
		ctrl_t      reply;
		ctrl_t      peer;
		err_t       err;
		cls_t       cls;
		bit [7:0]   ftype;
		bit [11:0]  plen;
	} frame_result_t;

	class rx_frame_tracker;
		bit            in_frame;
		bit            esc_pending;
		bit            bad_seen;
		int unsigned   raw_cnt;
		int unsigned   dec_cnt;
		bit [7:0]      type_byte;
		bit [7:0]      tail[2];
		bit [15:0]     body_crc;
		bit [7:0]      retry_cnt;
		bit [7:0]      retry_limit;
		frame_result_t due_results[$];
		int unsigned   mismatches;

		function new();
			in_frame = 1'b0;
			esc_pending = 1'b0;
			bad_seen = 1'b0;
			raw_cnt = 0;
			dec_cnt = 0;
			type_byte = 8'h00;
			tail[0] = 8'h00;
			tail[1] = 8'h00;
			body_crc = 16'h0000;
			retry_cnt = 8'h00;
			retry_limit = RETRY_LIMIT_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_retry_limit(bit [7:0] v);
			retry_limit = v;
		endfunction

		// A failed frame is answered with NACK until the limit is used up, then CAN.
		function ctrl_t reject_reply();
			if (retry_cnt < retry_limit) begin
				retry_cnt++;
				return CTRL_NACK;
			end
			retry_cnt = 8'h00;
			return CTRL_CAN;
		endfunction

		function void add_status(ctrl_t reply, ctrl_t peer, err_t err, cls_t cls);
			frame_result_t r;
			int unsigned plen;
			plen = (dec_cnt >= 2) ? dec_cnt - 2 : 0;
			if (plen > 4095) plen = 4095;
			r.kind = 1'b1;
			r.data = 8'h00;
			r.reply = reply;
			r.peer = peer;
			r.err = err;
			r.cls = cls;
			r.ftype = (raw_cnt != 0) ? type_byte : 8'h00;
			r.plen = plen[11:0];
			due_results.push_back(r);
		endfunction

		// Decoded bytes pass a two-byte delay so that the CRC never leaves as payload.
		function void add_decoded(bit [7:0] d);
			frame_result_t r;
			if (dec_cnt < 2) begin
				tail[dec_cnt] = d;
				dec_cnt++;
				return;
			end
			r.kind = 1'b0;
			r.data = tail[0];
			r.reply = CTRL_NONE;
			r.peer = CTRL_NONE;
			r.err = ERR_OK;
			r.cls = CLS_NONE;
			r.ftype = 8'h00;
			r.plen = 12'h000;
			due_results.push_back(r);
			body_crc = xmodem_next(body_crc, tail[0]);
			tail[0] = tail[1];
			tail[1] = d;
			dec_cnt++;
		endfunction

		function void close_frame();
			cls_t cls;
			in_frame = 1'b0;
			if (raw_cnt == 0) begin
				add_status(reject_reply(), CTRL_NONE, ERR_EMPTY, CLS_NONE);
			end else if (raw_cnt == 1) begin
				case (type_byte)
					BYTE_ACK: add_status(CTRL_NONE, CTRL_ACK, ERR_OK, CLS_NONE);
					BYTE_NACK: add_status(CTRL_NONE, CTRL_NACK, ERR_OK, CLS_NONE);
					BYTE_CAN: add_status(CTRL_NONE, CTRL_CAN, ERR_OK, CLS_NONE);
					default: add_status(reject_reply(), CTRL_NONE, ERR_UNKNOWN, CLS_NONE);
				endcase
			end else if (raw_cnt < MIN_BODY_BYTES) begin
				add_status(reject_reply(), CTRL_NONE, ERR_SHORT, CLS_NONE);
			end else if (type_byte > TYPE_MAX) begin
				add_status(reject_reply(), CTRL_NONE, ERR_TYPE, CLS_NONE);
			end else if (bad_seen || esc_pending || dec_cnt < 2) begin
				add_status(reject_reply(), CTRL_NONE, ERR_BAD_BYTE, CLS_NONE);
			end else if (body_crc != {tail[0], tail[1]}) begin
				add_status(reject_reply(), CTRL_NONE, ERR_CRC, CLS_NONE);
			end else begin
				if (type_byte <= DATA_TYPE_MAX) cls = CLS_DATA;
				else if (type_byte <= RESP_TYPE_MAX) cls = CLS_RESPONSE;
				else cls = CLS_UNSOLICITED;
				retry_cnt = 8'h00;
				add_status(CTRL_ACK, CTRL_NONE, ERR_OK, cls);
			end
		endfunction

		function void take_line_byte(bit [7:0] b);
			if (!in_frame) begin
				if (b == BYTE_START) begin
					in_frame = 1'b1;
					esc_pending = 1'b0;
					bad_seen = 1'b0;
					raw_cnt = 0;
					dec_cnt = 0;
					type_byte = 8'h00;
					body_crc = 16'h0000;
				end
				return;
			end
			if (b == BYTE_END) begin
				close_frame();
				return;
			end
			if (raw_cnt >= MAX_FRAME_BYTES) begin
				in_frame = 1'b0;
				add_status(CTRL_NONE, CTRL_NONE, ERR_OVERRUN, CLS_NONE);
				return;
			end
			if (raw_cnt == 0) type_byte = b;
			raw_cnt++;
			if (esc_pending) begin
				esc_pending = 1'b0;
				add_decoded(b ^ ESC_XOR);
				return;
			end
			if (b == BYTE_ESC) begin
				esc_pending = 1'b1;
				return;
			end
			if (b >= BYTE_ACK && b <= BYTE_CAN) bad_seen = 1'b1;
			add_decoded(b);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare(string field, logic [11:0] got, logic [11:0] want);
			if (got !== want) report($sformatf("%s is %0h, expected %0h", field, got, want));
		endtask

		task check_result(logic kind, logic [TDATA_W-1:0] d);
			frame_result_t w;
			if (due_results.size() == 0) begin
				report($sformatf("result kind %0b tdata %h with nothing expected", kind, d));
				return;
			end
			w = due_results.pop_front();
			compare("result_kind", 12'(kind), 12'(w.kind));
			compare("data_byte", 12'(d[7:0]), 12'(w.data));
			compare("reply", 12'(d[9:8]), 12'(w.reply));
			compare("peer_control", 12'(d[11:10]), 12'(w.peer));
			compare("frame_error", 12'(d[14:12]), 12'(w.err));
			compare("frame_class", 12'(d[16:15]), 12'(w.cls));
			compare("frame_type", 12'(d[24:17]), 12'(w.ftype));
			compare("payload_length", d[36:25], w.plen);
		endtask
	endclass

endpackage

@@ sim/tb_stuffed_frame_receiver_crc16.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench
// Drives raw line bytes into the receiver, follows every accepted item with a
// scoreboard of the frame state and checks each payload and status item in
// order, under random idling on both sides, a long output hold-off and a
// range of retry limits.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_crc16;

	import sfr_pkg::*;
	import sfr_tb_pkg::*;

	localparam int CLK_PERIOD = 12;
	// Cycles with no handshake anywhere before the run is declared hung. The
	// longest legal quiet stretch is the receiver hold-off below.
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef enum int {
		FLAW_NONE,
		FLAW_CRC,
		FLAW_BAD_BYTE,
		FLAW_ESC_AT_END
	} frame_flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [7:0]           cfg_data;

	rx_frame_tracker      sb;
	bit [7:0]             line_q[$];
	bit                   no_idle = 1'b0;
	int                   hold_asked = 0;
	int                   hold_served = 0;
	int                   hold_left = 0;
	int unsigned          quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	stuffed_frame_receiver_crc16 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),      // [7:0] rx_byte
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),      // data_byte, reply, peer_control, ... payload_length
		.m_tuser   (m_tuser),      // [0] result_kind
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Every handshake is observed at the clock edge, before the values driven
	// at that edge take effect. Results are checked before the input of the
	// same edge is noted, as an item cannot come out in the cycle it went in.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			if (cfg_valid && cfg_ready) sb.set_retry_limit(cfg_data);
			if (s_tvalid && s_tready) sb.take_line_byte(s_tdata);
		end
	end

	// The result side. It stalls about a third of the time, never during a
	// no-idle stretch, and holds off completely for a fixed number of cycles
	// whenever the stimulus asks for it, so that the internal queue fills up.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
		end
	end

	// Watchdog: a run that stops making progress is a failure.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** stuffed_frame_receiver_crc16: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one line byte and returns at the edge where it is taken. A gap,
	// if one is drawn, comes before the byte so that tvalid is never dropped
	// and raised in the same step. Each idle cycle is drawn on its own.
	task automatic send_byte(input bit [7:0] b);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_byte(line_q[i]);
		line_q.delete();
	endtask

	// Stops offering bytes until every expected item has arrived, then lets the
	// pipeline empty before it returns.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_retry_limit(input bit [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [7:0] any_but_end();
		bit [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == BYTE_END);
		return b;
	endfunction

	// Appends a decoded byte in line form. Special bytes must be escaped; an
	// ordinary byte is escaped now and then as well, which is legal.
	task automatic push_stuffed(input bit [7:0] d);
		if ((d >= BYTE_ESC && d <= BYTE_END) || $urandom_range(0, 15) == 0) begin
			line_q.push_back(BYTE_ESC);
			line_q.push_back(d ^ ESC_XOR);
		end else begin
			line_q.push_back(d);
		end
	endtask

	// Builds a whole frame: start, raw type byte, payload, big-endian CRC of
	// everything decoded, end. A flaw damages it in one chosen way.
	task automatic compose_frame(input bit [7:0] ftype, input int n, input frame_flaw_t flaw);
		bit [15:0] c;
		bit [7:0] d;
		int pos;
		line_q.push_back(BYTE_START);
		line_q.push_back(ftype);
		c = xmodem_next(16'h0000, ftype);
		pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
		for (int i = 0; i < n; i++) begin
			if (flaw == FLAW_BAD_BYTE && i == pos)
				line_q.push_back(8'($urandom_range(BYTE_ACK, BYTE_CAN)));
			d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(BYTE_ESC, BYTE_END))
				: 8'($urandom_range(0, 255));
			push_stuffed(d);
			c = xmodem_next(c, d);
		end
		if (flaw == FLAW_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
		push_stuffed(c[15:8]);
		push_stuffed(c[7:0]);
		if (flaw == FLAW_ESC_AT_END) line_q.push_back(BYTE_ESC);
		line_q.push_back(BYTE_END);
	endtask

	// Type bytes of good frames lean on the class boundaries.
	function automatic bit [7:0] good_type();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return DATA_TYPE_MAX;
			2: return DATA_TYPE_MAX + 8'h01;
			3: return RESP_TYPE_MAX;
			4: return RESP_TYPE_MAX + 8'h01;
			5: return TYPE_MAX;
			default: return 8'($urandom_range(0, TYPE_MAX));
		endcase
	endfunction

	function automatic int payload_size();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
	endfunction

	// Most of the traffic is well-formed frames with random content; the rest
	// covers control frames, garbage and every rejection other than an overrun.
	task automatic random_frame();
		int sel;
		bit [7:0] t;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			compose_frame(good_type(), payload_size(), FLAW_NONE);
		end else if (sel < 62) begin
			compose_frame(good_type(), payload_size(), FLAW_CRC);
		end else if (sel < 69) begin
			compose_frame(good_type(), payload_size() + 1, FLAW_BAD_BYTE);
		end else if (sel < 74) begin
			compose_frame(good_type(), payload_size(), FLAW_ESC_AT_END);
		end else if (sel < 79) begin
			do t = 8'($urandom_range(8'h80, 8'hFF)); while (t == BYTE_END);
			compose_frame(t, payload_size(), FLAW_NONE);
		end else if (sel < 84) begin
			line_q.push_back(BYTE_START);
			repeat ($urandom_range(2, 3)) line_q.push_back(any_but_end());
			line_q.push_back(BYTE_END);
		end else if (sel < 90) begin
			case ($urandom_range(0, 3))
				0: t = BYTE_ACK;
				1: t = BYTE_NACK;
				2: t = BYTE_CAN;
				default: t = any_but_end();
			endcase
			line_q = {BYTE_START, t, BYTE_END};
		end else if (sel < 94) begin
			line_q = {BYTE_START, BYTE_END};
		end else begin
			// Garbage: an end byte among the random ones closes the frame early
			// and the rest is ignored while hunting.
			line_q.push_back(BYTE_START);
			repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
			line_q.push_back(BYTE_END);
		end
	endtask

	// Sends frames until the given number of frame items has gone in. Line noise
	// between frames is not counted, and the block ignores it but for a start byte.
	task automatic random_traffic(input int unsigned n_items);
		int unsigned sent;
		bit [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			repeat ($urandom_range(0, 2)) begin
				b = 8'($urandom_range(0, 255));
				if (b == BYTE_START && $urandom_range(0, 7) != 0) b = 8'h00;
				send_byte(b);
			end
			random_frame();
			sent += line_q.size();
			send_line();
		end
	endtask

	task automatic directed_frames();
		bit [15:0] c;
		line_q = {BYTE_START, BYTE_END,                  // empty frame
			BYTE_START, BYTE_ACK, BYTE_END,              // control frames
			BYTE_START, BYTE_NACK, BYTE_END,
			BYTE_START, BYTE_CAN, BYTE_END,
			BYTE_START, BYTE_ESC, BYTE_END,              // lone escape: unknown control
			BYTE_START, 8'h01, BYTE_START, BYTE_END};    // start inside a short body
		send_line();
		// Smallest good frame, highest legal type, payload at both byte extremes.
		c = xmodem_next(xmodem_next(xmodem_next(16'h0000, TYPE_MAX), 8'h00), 8'hFF);
		line_q = {BYTE_START, TYPE_MAX, 8'h00, 8'hFF};
		push_stuffed(c[15:8]);
		push_stuffed(c[7:0]);
		line_q.push_back(BYTE_END);
		send_line();
		// Highest type byte, then an escape right before the end byte.
		line_q = {BYTE_START, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, BYTE_END,
			BYTE_START, 8'h10, 8'h11, 8'h12, 8'h13, BYTE_ESC, BYTE_END};
		send_line();
	endtask

	// The longest frame that is still accepted, sent while the result side
	// holds off, and then one raw byte too many, which drops the frame.
	task automatic long_frames();
		bit [15:0] c;
		bit [15:0] fin;
		bit [7:0] d;
		line_q = {BYTE_START, 8'h05};
		c = xmodem_next(16'h0000, 8'h05);
		for (int i = 0; i < MAX_FRAME_BYTES - 4; i++) begin
			d = 8'($urandom_range(0, 8'hDF));
			line_q.push_back(d);
			c = xmodem_next(c, d);
		end
		// Pick the last payload byte so that neither CRC byte needs escaping
		// and the body is exactly the maximum raw length.
		do begin
			d = 8'($urandom_range(0, 8'hDF));
			fin = xmodem_next(c, d);
		end while ((fin[15:8] >= BYTE_ESC && fin[15:8] <= BYTE_END) ||
			(fin[7:0] >= BYTE_ESC && fin[7:0] <= BYTE_END));
		line_q.push_back(d);
		line_q.push_back(fin[15:8]);
		line_q.push_back(fin[7:0]);
		line_q.push_back(BYTE_END);
		hold_asked++;
		send_line();

		line_q = {BYTE_START, 8'h22};
		repeat (MAX_FRAME_BYTES) line_q.push_back(any_but_end());
		// The end byte after the overrun arrives while hunting and is ignored.
		line_q.push_back(BYTE_END);
		send_line();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of the retry limit first.
		directed_frames();
		settle();

		// Every rejected frame answered with CAN.
		write_retry_limit(8'd0);
		random_traffic(250);
		settle();

		// One NACK before each CAN, with neither side idling.
		write_retry_limit(8'd1);
		no_idle = 1'b1;
		random_traffic(250);
		no_idle = 1'b0;
		settle();

		// Highest limit: failures other than the overrun are answered with NACK throughout.
		write_retry_limit(8'd255);
		long_frames();
		random_traffic(250);
		settle();

		write_retry_limit(8'($urandom_range(2, 6)));
		random_traffic(250);
		settle();

		write_retry_limit(RETRY_LIMIT_RESET);
		random_traffic(250);
		settle();

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** stuffed_frame_receiver_crc16: PASSED **");
		end else begin
			$display("** stuffed_frame_receiver_crc16: FAILED **");
		end
		$finish;
	end

endmodule
